// ===== design/boxds_pkg.sv =====
// ----------------------------------------------------------------------------
// boxds_pkg
// Shared types and constants of the box average downsampler: controller
// states, the command and status groups between controller and datapath,
// and the fixed field widths.
// ----------------------------------------------------------------------------
`default_nettype none

package boxds_pkg;

    localparam int PIX_W       = 8;   // input pixel width
    localparam int SUM_W       = 16;  // width of one running block sum
    localparam int QUOT_W      = 8;   // width of the averaged result
    localparam int STEP_W      = 3;   // index of one quotient bit
    localparam int COORD_W     = 12;  // output coordinate width
    localparam int SIZE_CFG_W  = 13;  // image_width and image_height
    localparam int FACT_CFG_W  = 5;   // block_factor
    localparam int APB_DATA_W  = 32;
    localparam int APB_ADDR_W  = 4;

    typedef enum logic [1:0] {
        REG_IMAGE_WIDTH  = 2'd0,
        REG_IMAGE_HEIGHT = 2'd1,
        REG_BLOCK_FACTOR = 2'd2
    } reg_idx_t;

    typedef enum logic [1:0] {
        S_IDLE,
        S_ACCUM,
        S_DIV,
        S_EMIT
    } state_t;

    typedef struct packed {
        logic              accept;    // latch pixel, read column sum, step counters
        logic              accum;     // add pixel, write column sum back
        logic              div_en;    // one restoring division step
        logic [STEP_W-1:0] div_step;  // quotient bit being resolved
        logic              load_out;  // move quotient into the output register
    } cmd_t;

    typedef struct packed {
        logic active;    // current pixel belongs to a whole block
        logic complete;  // latched pixel closes its block
    } status_t;

endpackage

`default_nettype wire

// ===== design/boxds_ctrl.sv =====
// ----------------------------------------------------------------------------
// boxds_ctrl
// Controller of the box average downsampler. Sequences pixel accept,
// column sum update, the bit-serial division and the result handoff.
// ----------------------------------------------------------------------------
`default_nettype none

module boxds_ctrl (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              pix_valid,
    output logic                   pix_ready,
    output logic                   res_valid,
    input  wire logic              res_ready,
    input  wire boxds_pkg::status_t status,
    output boxds_pkg::cmd_t        cmd
);

    boxds_pkg::state_t                 state_reg, state_next;
    logic [boxds_pkg::STEP_W-1:0]      step_reg, step_next;
    logic                              res_valid_reg, res_valid_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= boxds_pkg::S_IDLE;
            step_reg      <= '0;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            step_reg      <= step_next;
            res_valid_reg <= res_valid_next;
        end
    end

    always_comb
    begin
        cmd            = '0;
        state_next     = state_reg;
        step_next      = step_reg;
        pix_ready      = 1'b0;
        res_valid_next = res_valid_reg && !res_ready;
        unique case (state_reg)
            boxds_pkg::S_IDLE:
            begin
                pix_ready = 1'b1;
                if (pix_valid)
                begin
                    cmd.accept = 1'b1;
                    if (status.active)
                        state_next = boxds_pkg::S_ACCUM;
                end
            end
            boxds_pkg::S_ACCUM:
            begin
                cmd.accum = 1'b1;
                if (status.complete)
                begin
                    step_next  = boxds_pkg::STEP_W'(boxds_pkg::QUOT_W - 1);
                    state_next = boxds_pkg::S_DIV;
                end
                else
                    state_next = boxds_pkg::S_IDLE;
            end
            boxds_pkg::S_DIV:
            begin
                cmd.div_en   = 1'b1;
                cmd.div_step = step_reg;
                if (step_reg == '0)
                    state_next = boxds_pkg::S_EMIT;
                else
                    step_next = step_reg - boxds_pkg::STEP_W'(1);
            end
            boxds_pkg::S_EMIT:
            begin
                // The output register is free or is emptied at this edge.
                if (!res_valid_reg || res_ready)
                begin
                    cmd.load_out   = 1'b1;
                    res_valid_next = 1'b1;
                    state_next     = boxds_pkg::S_IDLE;
                end
            end
        endcase
    end

    assign res_valid = res_valid_reg;

`ifndef SYNTHESIS
    a_active_to_accum: assert property (@(posedge clk) disable iff (!rst_n)
        (pix_valid && pix_ready && status.active) |=> state_reg == boxds_pkg::S_ACCUM)
        else $error("active pixel did not enter accumulation");

    a_complete_to_div: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == boxds_pkg::S_ACCUM && status.complete)
        |=> (state_reg == boxds_pkg::S_DIV &&
             step_reg == boxds_pkg::STEP_W'(boxds_pkg::QUOT_W - 1)))
        else $error("division did not start at the top quotient bit");

    a_div_done: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == boxds_pkg::S_DIV && step_reg == '0) |=> state_reg == boxds_pkg::S_EMIT)
        else $error("division did not end after the last quotient bit");

    a_load_sets_valid: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.load_out |=> res_valid_reg)
        else $error("loaded result is not presented");
`endif

endmodule

`default_nettype wire

// ===== design/boxds_datapath.sv =====
// ----------------------------------------------------------------------------
// boxds_datapath
// Datapath of the box average downsampler: position counters, the column
// sum memory, a restoring divider that resolves one quotient bit per cycle,
// and the output payload register.
// ----------------------------------------------------------------------------
`default_nettype none

module boxds_datapath #(
    parameter int MAX_WIDTH  = 4096,
    parameter int MAX_HEIGHT = 4096,
    parameter int MAX_FACTOR = 16
) (
    input  wire logic                                 clk,
    input  wire logic                                 rst_n,
    input  wire logic [boxds_pkg::SIZE_CFG_W-1:0]     image_width,
    input  wire logic [boxds_pkg::SIZE_CFG_W-1:0]     image_height,
    input  wire logic [boxds_pkg::FACT_CFG_W-1:0]     block_factor,
    input  wire logic                                 cfg_restart,
    input  wire logic [boxds_pkg::PIX_W-1:0]          pixel_value,
    input  wire boxds_pkg::cmd_t                      cmd,
    output boxds_pkg::status_t                        status,
    output logic [boxds_pkg::QUOT_W-1:0]              avg_value,
    output logic [boxds_pkg::COORD_W-1:0]             out_col,
    output logic [boxds_pkg::COORD_W-1:0]             out_row,
    output logic                                      frame_last
);

    localparam int CW   = $clog2(MAX_WIDTH);
    localparam int RW   = $clog2(MAX_HEIGHT);
    localparam int FW   = $clog2(MAX_FACTOR);
    localparam int KW   = $clog2(MAX_FACTOR + 1);
    localparam int WEW  = $clog2(MAX_WIDTH + 1);
    localparam int HEW  = $clog2(MAX_HEIGHT + 1);
    localparam int FITW = $clog2(MAX_WIDTH + 2 * MAX_FACTOR + 1);
    localparam int FITH = $clog2(MAX_HEIGHT + 2 * MAX_FACTOR + 1);
    localparam int KKW  = $clog2(MAX_FACTOR * MAX_FACTOR + 1);
    localparam int DVW  = (KKW + boxds_pkg::QUOT_W > boxds_pkg::SUM_W) ?
                          KKW + boxds_pkg::QUOT_W : boxds_pkg::SUM_W;

    localparam int SUM_W = boxds_pkg::SUM_W;
    localparam int QW    = boxds_pkg::QUOT_W;

    // Effective sizes: zero reads as one, large values saturate.
    logic [WEW-1:0] w_eff;
    logic [HEW-1:0] h_eff;
    logic [KW-1:0]  k_eff;

    assign w_eff = (image_width == '0) ? WEW'(1) :
                   (32'(image_width) > 32'(MAX_WIDTH)) ? WEW'(MAX_WIDTH) : WEW'(image_width);
    assign h_eff = (image_height == '0) ? HEW'(1) :
                   (32'(image_height) > 32'(MAX_HEIGHT)) ? HEW'(MAX_HEIGHT) :
                   HEW'(image_height);
    assign k_eff = (block_factor == '0) ? KW'(1) :
                   (32'(block_factor) > 32'(MAX_FACTOR)) ? KW'(MAX_FACTOR) : KW'(block_factor);

    // Position counters.
    logic [CW-1:0] pixel_col_reg, pixel_col_next;
    logic [RW-1:0] pixel_row_reg, pixel_row_next;
    logic [FW-1:0] ib_col_reg, ib_col_next;
    logic [FW-1:0] ib_row_reg, ib_row_next;
    logic [CW-1:0] block_col_reg, block_col_next;
    logic [RW-1:0] block_row_reg, block_row_next;

    logic           ib_col_wrap, ib_row_wrap;
    logic [WEW-1:0] pc_inc;
    logic [HEW-1:0] pr_inc;

    assign ib_col_wrap = (KW'(ib_col_reg) == k_eff - KW'(1));
    assign ib_row_wrap = (KW'(ib_row_reg) == k_eff - KW'(1));
    assign pc_inc      = WEW'(pixel_col_reg) + WEW'(1);
    assign pr_inc      = HEW'(pixel_row_reg) + HEW'(1);

    always_comb
    begin
        pixel_col_next = pixel_col_reg;
        pixel_row_next = pixel_row_reg;
        ib_col_next    = ib_col_reg;
        ib_row_next    = ib_row_reg;
        block_col_next = block_col_reg;
        block_row_next = block_row_reg;
        if (cfg_restart)
        begin
            pixel_col_next = '0;
            pixel_row_next = '0;
            ib_col_next    = '0;
            ib_row_next    = '0;
            block_col_next = '0;
            block_row_next = '0;
        end
        else if (cmd.accept)
        begin
            if (pc_inc >= w_eff)
            begin
                pixel_col_next = '0;
                ib_col_next    = '0;
                block_col_next = '0;
                if (pr_inc >= h_eff)
                begin
                    pixel_row_next = '0;
                    ib_row_next    = '0;
                    block_row_next = '0;
                end
                else
                begin
                    pixel_row_next = RW'(pr_inc);
                    if (ib_row_wrap)
                    begin
                        ib_row_next    = '0;
                        block_row_next = block_row_reg + RW'(1);
                    end
                    else
                        ib_row_next = ib_row_reg + FW'(1);
                end
            end
            else
            begin
                pixel_col_next = CW'(pc_inc);
                if (ib_col_wrap)
                begin
                    ib_col_next    = '0;
                    block_col_next = block_col_reg + CW'(1);
                end
                else
                    ib_col_next = ib_col_reg + FW'(1);
            end
        end
    end

    // A block is whole when its start plus k stays inside the image; it is
    // the last one of its row or column when a further block would not fit.
    logic [FITW-1:0] start_col, k_fw;
    logic [FITH-1:0] start_row, k_fh;
    logic            col_fit, row_fit, col_last, row_last;

    assign start_col = FITW'(pixel_col_reg) - FITW'(ib_col_reg);
    assign start_row = FITH'(pixel_row_reg) - FITH'(ib_row_reg);
    assign k_fw      = FITW'(k_eff);
    assign k_fh      = FITH'(k_eff);
    assign col_fit   = (start_col + k_fw) <= FITW'(w_eff);
    assign row_fit   = (start_row + k_fh) <= FITH'(h_eff);
    assign col_last  = (start_col + k_fw + k_fw) > FITW'(w_eff);
    assign row_last  = (start_row + k_fh + k_fh) > FITH'(h_eff);

    logic complete_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pixel_col_reg <= '0;
            pixel_row_reg <= '0;
            ib_col_reg    <= '0;
            ib_row_reg    <= '0;
            block_col_reg <= '0;
            block_row_reg <= '0;
            complete_reg  <= 1'b0;
        end
        else
        begin
            pixel_col_reg <= pixel_col_next;
            pixel_row_reg <= pixel_row_next;
            ib_col_reg    <= ib_col_next;
            ib_row_reg    <= ib_row_next;
            block_col_reg <= block_col_next;
            block_row_reg <= block_row_next;
            if (cmd.accept)
                complete_reg <= ib_col_wrap && ib_row_wrap;
        end
    end

    assign status.active   = col_fit && row_fit;
    assign status.complete = complete_reg;

    // Latched item and column sum memory.
    logic [boxds_pkg::PIX_W-1:0] pix_reg;
    logic                        first_reg;
    logic                        last_reg;
    logic [CW-1:0]               col_reg;
    logic [RW-1:0]               row_reg;
    logic [SUM_W-1:0]            rd_reg;
    logic [SUM_W-1:0]            sum;
    logic [SUM_W-1:0]            col_sum_mem [MAX_WIDTH];

    // The top-left pixel of a block starts a fresh sum.
    assign sum = first_reg ? SUM_W'(pix_reg) : rd_reg + SUM_W'(pix_reg);

    always_ff @(posedge clk)
    begin
        if (cmd.accept)
        begin
            pix_reg   <= pixel_value;
            first_reg <= (ib_col_reg == '0) && (ib_row_reg == '0);
            last_reg  <= col_last && row_last;
            col_reg   <= block_col_reg;
            row_reg   <= block_row_reg;
            rd_reg    <= col_sum_mem[block_col_reg];
        end
        if (cmd.accum)
            col_sum_mem[col_reg] <= sum;
    end

    // Restoring division by k squared, one quotient bit per cycle.
    logic [KKW-1:0]   kk_reg;
    logic [SUM_W-1:0] rem_reg;
    logic [QW-1:0]    quot_reg;
    logic [DVW-1:0]   trial;
    logic             fits;

    assign trial = DVW'(kk_reg) << cmd.div_step;
    assign fits  = DVW'(rem_reg) >= trial;

    always_ff @(posedge clk)
    begin
        kk_reg <= KKW'(KKW'(k_eff) * KKW'(k_eff));
        if (cmd.accum)
        begin
            rem_reg  <= sum;
            quot_reg <= '0;
        end
        else if (cmd.div_en && fits)
        begin
            rem_reg  <= SUM_W'(DVW'(rem_reg) - trial);
            quot_reg <= quot_reg | (QW'(1) << cmd.div_step);
        end
        if (cmd.load_out)
        begin
            avg_value  <= quot_reg;
            out_col    <= boxds_pkg::COORD_W'(col_reg);
            out_row    <= boxds_pkg::COORD_W'(row_reg);
            frame_last <= last_reg;
        end
    end

endmodule

`default_nettype wire

// ===== design/box_average_downsampler.sv =====
// ----------------------------------------------------------------------------
// box_average_downsampler
// Averages k-by-k blocks of an 8-bit raster stream into one result per block.
//
//   Channel   Handshake              Payload
//   pixel     pix_valid/pix_ready    pixel_value
//   result    res_valid/res_ready    avg_value, out_col, out_row, frame_last
//   config    APB psel/penable       image_width, image_height, block_factor
//
// A pixel outside any whole block is only counted, a pixel inside a block
// also has its column sum read, then written back, and the pixel that closes a block
// then passes through the divider, which resolves one quotient bit per cycle.
// The result sits in an output register, so a stalled result blocks only the
// next block's handoff. Reset clears the position counters; the column sum memory
// needs no clearing since each block's first pixel overwrites its entry.
// Any write to a defined register restarts the frame.
// ----------------------------------------------------------------------------
`default_nettype none

module box_average_downsampler #(
    parameter int MAX_WIDTH  = 4096,
    parameter int MAX_HEIGHT = 4096,
    parameter int MAX_FACTOR = 16
) (
    input  wire logic                                 clk,
    input  wire logic                                 rst_n,
    input  wire logic                                 psel,
    input  wire logic                                 penable,
    input  wire logic                                 pwrite,
    input  wire logic [boxds_pkg::APB_ADDR_W-1:0]     paddr,
    input  wire logic [boxds_pkg::APB_DATA_W-1:0]     pwdata,
    output logic [boxds_pkg::APB_DATA_W-1:0]          prdata,
    output logic                                      pready,
    input  wire logic                                 pix_valid,
    output logic                                      pix_ready,
    input  wire logic [boxds_pkg::PIX_W-1:0]          pixel_value,
    output logic                                      res_valid,
    input  wire logic                                 res_ready,
    output logic [boxds_pkg::QUOT_W-1:0]              avg_value,
    output logic [boxds_pkg::COORD_W-1:0]             out_col,
    output logic [boxds_pkg::COORD_W-1:0]             out_row,
    output logic                                      frame_last
);

    localparam int DW = boxds_pkg::APB_DATA_W;

    logic [boxds_pkg::SIZE_CFG_W-1:0] image_width_reg;
    logic [boxds_pkg::SIZE_CFG_W-1:0] image_height_reg;
    logic [boxds_pkg::FACT_CFG_W-1:0] block_factor_reg;
    logic                             wr_en;
    logic                             cfg_restart;
    boxds_pkg::reg_idx_t              reg_idx;

    assign pready  = 1'b1;
    assign wr_en   = psel && penable && pwrite && pready;
    assign reg_idx = boxds_pkg::reg_idx_t'(paddr[3:2]);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            image_width_reg  <= boxds_pkg::SIZE_CFG_W'(640);
            image_height_reg <= boxds_pkg::SIZE_CFG_W'(480);
            block_factor_reg <= boxds_pkg::FACT_CFG_W'(2);
        end
        else if (wr_en)
        begin
            unique case (reg_idx)
                boxds_pkg::REG_IMAGE_WIDTH:
                    image_width_reg <= pwdata[boxds_pkg::SIZE_CFG_W-1:0];
                boxds_pkg::REG_IMAGE_HEIGHT:
                    image_height_reg <= pwdata[boxds_pkg::SIZE_CFG_W-1:0];
                boxds_pkg::REG_BLOCK_FACTOR:
                    block_factor_reg <= pwdata[boxds_pkg::FACT_CFG_W-1:0];
                default:
                begin
                end
            endcase
        end
    end

    // Only writes to a defined register restart the frame.
    always_comb
    begin
        cfg_restart = 1'b0;
        prdata      = '0;
        unique case (reg_idx)
            boxds_pkg::REG_IMAGE_WIDTH:
            begin
                cfg_restart = wr_en;
                prdata      = DW'(image_width_reg);
            end
            boxds_pkg::REG_IMAGE_HEIGHT:
            begin
                cfg_restart = wr_en;
                prdata      = DW'(image_height_reg);
            end
            boxds_pkg::REG_BLOCK_FACTOR:
            begin
                cfg_restart = wr_en;
                prdata      = DW'(block_factor_reg);
            end
            default:
            begin
                cfg_restart = 1'b0;
                prdata      = '0;
            end
        endcase
    end

    boxds_pkg::cmd_t    cmd;
    boxds_pkg::status_t status;

    boxds_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .pix_valid (pix_valid),
        .pix_ready (pix_ready),
        .res_valid (res_valid),
        .res_ready (res_ready),
        .status    (status),
        .cmd       (cmd)
    );

    boxds_datapath #(
        .MAX_WIDTH  (MAX_WIDTH),
        .MAX_HEIGHT (MAX_HEIGHT),
        .MAX_FACTOR (MAX_FACTOR)
    ) u_datapath (
        .clk          (clk),
        .rst_n        (rst_n),
        .image_width  (image_width_reg),
        .image_height (image_height_reg),
        .block_factor (block_factor_reg),
        .cfg_restart  (cfg_restart),
        .pixel_value  (pixel_value),
        .cmd          (cmd),
        .status       (status),
        .avg_value    (avg_value),
        .out_col      (out_col),
        .out_row      (out_row),
        .frame_last   (frame_last)
    );

endmodule

`default_nettype wire

// ===== tb/sv/tb_box_average_downsampler.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_box_average_downsampler
// Self-checking bench for the k-by-k box average downsampler. Pixels are
// driven from a queue by a clocked driver with random gaps. A clocked monitor
// takes results under random back-pressure and compares every field against
// block averages predicted by an independent model of the position counters
// and column sums. Frame geometry and block size are reprogrammed over APB
// between phases, with read-back, and include out-of-range register values.
// ----------------------------------------------------------------------------
`default_nettype none

module tb_box_average_downsampler;

    localparam int PIX_W      = boxds_pkg::PIX_W;
    localparam int SUM_W      = boxds_pkg::SUM_W;
    localparam int QUOT_W     = boxds_pkg::QUOT_W;
    localparam int COORD_W    = boxds_pkg::COORD_W;
    localparam int SIZE_CFG_W = boxds_pkg::SIZE_CFG_W;
    localparam int FACT_CFG_W = boxds_pkg::FACT_CFG_W;
    localparam int APB_DATA_W = boxds_pkg::APB_DATA_W;
    localparam int APB_ADDR_W = boxds_pkg::APB_ADDR_W;

    localparam int MAX_W         = 4096;
    localparam int MAX_H         = 4096;
    localparam int MAX_K         = 16;
    localparam int RANDOM_ITEMS  = 1800;
    localparam int SETTLE_CYCLES = 24;
    localparam logic [APB_ADDR_W-1:0] ADDR_UNMAPPED = 4'd12;

    typedef struct {
        logic [QUOT_W-1:0]  avg;
        logic [COORD_W-1:0] col;
        logic [COORD_W-1:0] row;
        logic               last;
    } block_avg_t;

    logic                  clk = 1'b0;
    logic                  rst_n = 1'b0;
    logic                  psel = 1'b0;
    logic                  penable = 1'b0;
    logic                  pwrite = 1'b0;
    logic [APB_ADDR_W-1:0] paddr = '0;
    logic [APB_DATA_W-1:0] pwdata = '0;
    logic [APB_DATA_W-1:0] prdata;
    logic                  pready;
    logic                  pix_valid = 1'b0;
    logic                  pix_ready;
    logic [PIX_W-1:0]      pixel_value = '0;
    logic                  res_valid;
    logic                  res_ready = 1'b0;
    logic [QUOT_W-1:0]     avg_value;
    logic [COORD_W-1:0]    out_col;
    logic [COORD_W-1:0]    out_row;
    logic                  frame_last;

    box_average_downsampler u_top (
        .clk         (clk),
        .rst_n       (rst_n),
        .psel        (psel),
        .penable     (penable),
        .pwrite      (pwrite),
        .paddr       (paddr),
        .pwdata      (pwdata),
        .prdata      (prdata),
        .pready      (pready),
        .pix_valid   (pix_valid),
        .pix_ready   (pix_ready),
        .pixel_value (pixel_value),
        .res_valid   (res_valid),
        .res_ready   (res_ready),
        .avg_value   (avg_value),
        .out_col     (out_col),
        .out_row     (out_row),
        .frame_last  (frame_last)
    );

    // Stimulus and scoreboard state.
    logic [PIX_W-1:0] pixels_to_send[$];
    block_avg_t       block_avgs_due[$];
    logic             pix_taken = 1'b0;
    int               idle_pct = 15;
    int               mismatches = 0;
    int               pixels_fed = 0;
    int               blocks_checked = 0;
    int               settings_used = 0;

    // Shadow of the registers and of the frame position.
    logic [SIZE_CFG_W-1:0] cur_width = 13'd640;
    logic [SIZE_CFG_W-1:0] cur_height = 13'd480;
    logic [FACT_CFG_W-1:0] cur_factor = 5'd2;
    logic [SUM_W-1:0]      col_sum[MAX_W];
    int unsigned           in_col, blk_col, in_row, blk_row, pix_col, pix_row;

    initial
    begin
        forever #2 clk = ~clk;
    end

    initial
    begin
        #2_000_000;
        $display("[FAIL] regression broken");
        $finish;
    end

    function automatic int unsigned clamp_size(int unsigned v, int unsigned hi);
        if (v == 0) return 1;
        if (v > hi) return hi;
        return v;
    endfunction

    function automatic void restart_frame();
        in_col  = 0;
        blk_col = 0;
        in_row  = 0;
        blk_row = 0;
        pix_col = 0;
        pix_row = 0;
    endfunction

    // Advance the frame position by one pixel and queue the block average
    // when this pixel closes a whole block.
    function automatic void accumulate_pixel(logic [PIX_W-1:0] pix);
        int unsigned w, h, k, out_w, out_h, acc;
        block_avg_t  res;
        w = clamp_size(32'(cur_width), MAX_W);
        h = clamp_size(32'(cur_height), MAX_H);
        k = clamp_size(32'(cur_factor), MAX_K);
        out_w = w / k;
        out_h = h / k;
        if (blk_col < out_w && blk_row < out_h) begin
            if (in_row == 0 && in_col == 0)
                acc = 32'(pix);
            else
                acc = (32'(col_sum[blk_col]) + 32'(pix)) & 32'hFFFF;
            col_sum[blk_col] = acc[SUM_W-1:0];
            if (in_row == k - 1 && in_col == k - 1) begin
                res.avg  = QUOT_W'(acc / (k * k));
                res.col  = blk_col[COORD_W-1:0];
                res.row  = blk_row[COORD_W-1:0];
                res.last = (blk_col == out_w - 1) && (blk_row == out_h - 1);
                block_avgs_due.push_back(res);
            end
        end
        pix_col++;
        in_col++;
        if (in_col >= k) begin
            in_col = 0;
            blk_col++;
        end
        if (pix_col >= w) begin
            pix_col = 0;
            in_col  = 0;
            blk_col = 0;
            pix_row++;
            in_row++;
            if (in_row >= k) begin
                in_row = 0;
                blk_row++;
            end
            if (pix_row >= h)
                restart_frame();
        end
    endfunction

    task automatic report_mismatch(string msg);
        mismatches++;
        if (mismatches <= 40)
            $display("mismatch at %0t ns: %s", $time, msg);
    endtask

    task automatic compare_field(string name, int got, int want, block_avg_t exp_blk);
        if (got != want)
            report_mismatch($sformatf("%s got %0d, want %0d (block col %0d row %0d)",
                                      name, got, want, exp_blk.col, exp_blk.row));
    endtask

    task automatic check_block_avg();
        block_avg_t exp_blk;
        if (block_avgs_due.size() == 0) begin
            report_mismatch($sformatf("unexpected result avg %0d col %0d row %0d last %0d",
                                      avg_value, out_col, out_row, frame_last));
        end
        else begin
            exp_blk = block_avgs_due.pop_front();
            compare_field("avg_value", int'(avg_value), int'(exp_blk.avg), exp_blk);
            compare_field("out_col", int'(out_col), int'(exp_blk.col), exp_blk);
            compare_field("out_row", int'(out_row), int'(exp_blk.row), exp_blk);
            compare_field("frame_last", int'(frame_last), int'(exp_blk.last), exp_blk);
            blocks_checked++;
        end
    endtask

    // Driver: a new item goes out only once the previous one was taken.
    always @(negedge clk)
    begin
        if (!pix_valid || pix_taken) begin
            if (pixels_to_send.size() > 0 && $urandom_range(99) >= idle_pct) begin
                pix_valid   <= 1'b1;
                pixel_value <= pixels_to_send.pop_front();
            end
            else begin
                pix_valid <= 1'b0;
            end
        end
        res_ready <= ($urandom_range(99) >= idle_pct);
    end

    // Monitor: predict on every accepted pixel, check every accepted result.
    always @(posedge clk)
    begin
        pix_taken <= pix_valid && pix_ready;
        if (rst_n && pix_valid && pix_ready) begin
            accumulate_pixel(pixel_value);
            pixels_fed++;
        end
        if (rst_n && res_valid && res_ready)
            check_block_avg();
    end

    function automatic logic [APB_ADDR_W-1:0] reg_addr(boxds_pkg::reg_idx_t r);
        return {r, 2'b00};
    endfunction

    function automatic logic [APB_DATA_W-1:0] reg_mask(boxds_pkg::reg_idx_t r);
        if (r == boxds_pkg::REG_BLOCK_FACTOR)
            return (1 << FACT_CFG_W) - 1;
        return (1 << SIZE_CFG_W) - 1;
    endfunction

    task automatic cfg_write(logic [APB_ADDR_W-1:0] addr, logic [APB_DATA_W-1:0] data);
        @(negedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= addr;
        pwdata  <= data;
        @(negedge clk);
        penable <= 1'b1;
        do @(posedge clk); while (!pready);
        // Writes to an address outside the register map leave the frame alone.
        if (addr == reg_addr(boxds_pkg::REG_IMAGE_WIDTH)) begin
            cur_width = data[SIZE_CFG_W-1:0];
            restart_frame();
        end
        else if (addr == reg_addr(boxds_pkg::REG_IMAGE_HEIGHT)) begin
            cur_height = data[SIZE_CFG_W-1:0];
            restart_frame();
        end
        else if (addr == reg_addr(boxds_pkg::REG_BLOCK_FACTOR)) begin
            cur_factor = data[FACT_CFG_W-1:0];
            restart_frame();
        end
        settings_used++;
        @(negedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    task automatic cfg_read_check(boxds_pkg::reg_idx_t r, logic [APB_DATA_W-1:0] want);
        @(negedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        paddr   <= reg_addr(r);
        @(negedge clk);
        penable <= 1'b1;
        do @(posedge clk); while (!pready);
        if (prdata !== want)
            report_mismatch($sformatf("register %s reads %0d, want %0d", r.name(), prdata, want));
        @(negedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    // Occasionally junk is put in the upper bits; the register keeps only its own.
    task automatic set_reg(boxds_pkg::reg_idx_t r, int unsigned v);
        logic [APB_DATA_W-1:0] data;
        data = v;
        if ($urandom_range(4) == 0)
            data[APB_DATA_W-1:16] = 16'($urandom);
        cfg_write(reg_addr(r), data);
        cfg_read_check(r, data & reg_mask(r));
    endtask

    task automatic set_geometry(int unsigned w, int unsigned h, int unsigned k);
        set_reg(boxds_pkg::REG_IMAGE_WIDTH, w);
        set_reg(boxds_pkg::REG_IMAGE_HEIGHT, h);
        set_reg(boxds_pkg::REG_BLOCK_FACTOR, k);
    endtask

    function automatic int unsigned pick_size();
        int unsigned r;
        r = $urandom_range(99);
        if (r < 70) return $urandom_range(1, 12);
        if (r < 90) return $urandom_range(1, 40);
        case ($urandom_range(3))
            0:       return 0;
            1:       return MAX_W;
            2:       return 8191;
            default: return $urandom_range(MAX_W + 1, 8191);
        endcase
    endfunction

    function automatic int unsigned pick_factor();
        int unsigned r;
        r = $urandom_range(99);
        if (r < 60) return $urandom_range(1, 4);
        if (r < 90) return $urandom_range(1, MAX_K);
        if (r < 95) return 0;
        return $urandom_range(MAX_K + 1, 31);
    endfunction

    // Pixels lean toward the two rails so that sums hit their extremes.
    task automatic feed_pixels(int n, bit all_high);
        int r;
        for (int i = 0; i < n; i++) begin
            r = $urandom_range(9);
            if (all_high || r == 0)
                pixels_to_send.push_back(8'hFF);
            else if (r == 1)
                pixels_to_send.push_back(8'h00);
            else
                pixels_to_send.push_back(PIX_W'($urandom_range(255)));
        end
    endtask

    // Wait until every pixel is taken and every block average has come back,
    // then give the datapath time to finish a pixel that closes no block.
    task automatic drain_pipeline();
        while (pixels_to_send.size() != 0 || pix_valid)
            @(posedge clk);
        while (block_avgs_due.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    initial
    begin
        int          random_items;
        int          phase;
        int          n;
        int unsigned w_eff, h_eff;

        random_items = 0;
        phase = 0;
        restart_frame();
        repeat (12) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Register values after reset, then a few pixels into a large frame.
        cfg_read_check(boxds_pkg::REG_IMAGE_WIDTH, 640);
        cfg_read_check(boxds_pkg::REG_IMAGE_HEIGHT, 480);
        cfg_read_check(boxds_pkg::REG_BLOCK_FACTOR, 2);
        pixels_to_send.push_back(8'h00);
        pixels_to_send.push_back(8'hFF);
        drain_pipeline();

        // Two 2x2 frames: all-high block, then a block that truncates to zero.
        // A write outside the register map lands in the middle of the second.
        set_geometry(2, 2, 2);
        feed_pixels(4, 1'b1);
        pixels_to_send.push_back(8'h00);
        pixels_to_send.push_back(8'h03);
        drain_pipeline();
        cfg_write(ADDR_UNMAPPED, 32'hFFFF_FFFF);
        pixels_to_send.push_back(8'h00);
        pixels_to_send.push_back(8'h00);
        drain_pipeline();

        // Zero width and zero factor both act as one.
        set_geometry(0, 2, 0);
        feed_pixels(2, 1'b0);
        drain_pipeline();

        // Leftover column and row around a 2x1 grid of blocks.
        set_geometry(5, 3, 2);
        feed_pixels(15, 1'b0);
        drain_pipeline();

        // Saturated width and factor, block taller than the image: no results.
        set_geometry(8191, 1, 31);
        feed_pixels(3, 1'b0);
        drain_pipeline();

        while (random_items < RANDOM_ITEMS) begin
            phase++;
            idle_pct = (phase == 3) ? 0 : 15;
            if (phase == 1) begin
                // Largest block, all pixels high: the biggest sum there is.
                set_geometry(16, 17, MAX_K);
                n = 16 * 17;
                feed_pixels(n, 1'b1);
            end
            else if (phase == 3) begin
                set_geometry(12, 10, 1);
                n = 240;
                feed_pixels(n, 1'b0);
            end
            else begin
                if ($urandom_range(3) != 0)
                    set_reg(boxds_pkg::REG_IMAGE_WIDTH, pick_size());
                if ($urandom_range(3) != 0)
                    set_reg(boxds_pkg::REG_IMAGE_HEIGHT, pick_size());
                if ($urandom_range(3) != 0)
                    set_reg(boxds_pkg::REG_BLOCK_FACTOR, pick_factor());
                if ($urandom_range(19) == 0)
                    cfg_write(ADDR_UNMAPPED, $urandom);
                w_eff = clamp_size(32'(cur_width), MAX_W);
                h_eff = clamp_size(32'(cur_height), MAX_H);
                if (w_eff * h_eff > 150)
                    n = $urandom_range(20, 300);
                else
                    n = w_eff * h_eff * $urandom_range(1, 2) + $urandom_range(0, w_eff);
                feed_pixels(n, 1'b0);
            end
            random_items += n;
            drain_pipeline();
        end

        $display("run covered %0d pixels over %0d register writes in %0d random phases",
                 pixels_fed, settings_used, phase);
        $display("%0d block averages compared field by field, %0d mismatches",
                 blocks_checked, mismatches);
        if (mismatches == 0 && block_avgs_due.size() == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule

`default_nettype wire

// ===== sim.f =====
design/boxds_pkg.sv
design/boxds_ctrl.sv
design/boxds_datapath.sv
design/box_average_downsampler.sv
tb/sv/tb_box_average_downsampler.sv
